### src/psc_pkg.sv
// Package for the pick sequence controller: phase and command codes, fixed-point
// constants and the elaboration-time arcsine table functions.
// No dependencies.
package psc_pkg;

    // Arcsine table resolution.
    localparam int ASIN_TABLE_DEPTH = 1024;

    // Arm geometry, Q.12.
    localparam int ARM_BASE_Z     = 1024;
    localparam int ARM_MIN_Z      = 418;
    localparam int ARM_MAX_Z      = 1548;
    localparam int ARM_INV_RADIUS = 20933;
    localparam int ARM_TOP_OFFSET = 524;
    localparam int ANGLE_MAX      = 6434;

    // The angle ROM is indexed by the magnitude of the height offset from the arm base.
    localparam int ROM_DEPTH = ARM_BASE_Z - ARM_MIN_Z + 1;
    localparam int ROM_AW    = $clog2(ROM_DEPTH);
    localparam int ANGLE_W   = 13;

    // Fixed command values.
    localparam logic signed [12:0] VEL_CREEP  = 13'sd410;
    localparam logic signed [12:0] VEL_LIMIT  = 13'sd2048;
    localparam logic signed [13:0] TUCK_ANGLE = 14'sd5734;
    localparam logic        [11:0] GRIP_OPEN  = 12'd2867;

    // Phase lengths in ticks.
    localparam logic [7:0] REACH_TICKS   = 8'd180;
    localparam logic [7:0] FORWARD_TICKS = 8'd30;
    localparam logic [7:0] GRIP_TICKS    = 8'd60;
    localparam logic [7:0] TUCK_TICKS    = 8'd90;
    localparam logic [7:0] BACK_TICKS    = 8'd30;
    localparam logic [7:0] DONE_TICKS    = 8'd5;
    localparam logic [7:0] COUNT_MAX     = 8'd255;

    // Sequencer phases.
    localparam logic [2:0] PH_READY   = 3'd0;
    localparam logic [2:0] PH_AIM     = 3'd1;
    localparam logic [2:0] PH_REACH   = 3'd2;
    localparam logic [2:0] PH_FORWARD = 3'd3;
    localparam logic [2:0] PH_GRIP    = 3'd4;
    localparam logic [2:0] PH_TUCK    = 3'd5;
    localparam logic [2:0] PH_BACK    = 3'd6;
    localparam logic [2:0] PH_DONE    = 3'd7;

    // Request kinds.
    localparam logic [1:0] KIND_START  = 2'd0;
    localparam logic [1:0] KIND_DETECT = 2'd1;
    localparam logic [1:0] KIND_TICK   = 2'd2;

    // Base velocity source.
    localparam logic [1:0] VS_ZERO = 2'd0;
    localparam logic [1:0] VS_AIM  = 2'd1;
    localparam logic [1:0] VS_FWD  = 2'd2;
    localparam logic [1:0] VS_BACK = 2'd3;

    // Arm command source.
    localparam logic [1:0] AS_NONE  = 2'd0;
    localparam logic [1:0] AS_REACH = 2'd1;
    localparam logic [1:0] AS_TUCK  = 2'd2;

    // Register indexes.
    localparam logic [2:0] REG_STANDOFF    = 3'd0;
    localparam logic [2:0] REG_LATERAL     = 3'd1;
    localparam logic [2:0] REG_GAIN_FWD    = 3'd2;
    localparam logic [2:0] REG_GAIN_LAT    = 3'd3;
    localparam logic [2:0] REG_HEIGHT      = 3'd4;
    localparam logic [2:0] REG_GRIP_CLOSED = 3'd5;
    localparam logic [2:0] REG_FWD_TOL     = 3'd6;
    localparam logic [2:0] REG_LAT_TOL     = 3'd7;

    // Register reset values.
    localparam logic        [14:0] STANDOFF_RST    = 15'd2458;
    localparam logic signed [15:0] LATERAL_RST     = 16'sd0;
    localparam logic        [13:0] GAIN_RST        = 14'd2048;
    localparam logic signed [12:0] HEIGHT_RST      = 13'(-41);
    localparam logic        [11:0] GRIP_CLOSED_RST = 12'd205;
    localparam logic        [11:0] FWD_TOL_RST     = 12'd41;
    localparam logic        [11:0] LAT_TOL_RST     = 12'd20;

    // Command set resolved by the sequencer for one tick.
    typedef struct packed {
        logic        mv;
        logic [1:0]  vsel;
        logic [1:0]  asel;
        logic        gv;
        logic [11:0] gw;
        logic        dr;
        logic [2:0]  ph;
    } t_cmd;

    // Sine of a Q.12 angle as Q.28, Taylor series to the 15th power.
    function automatic longint unsigned sine_q28(input int unsigned ang);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned t;
        longint unsigned s;
        x  = 64'(ang) << 16;
        x2 = (x * x) >> 28;
        t  = ((x * x2) >> 28) / 64'd6;
        s  = x - t;
        t  = ((t * x2) >> 28) / 64'd20;
        s  = s + t;
        t  = ((t * x2) >> 28) / 64'd42;
        s  = s - t;
        t  = ((t * x2) >> 28) / 64'd72;
        s  = s + t;
        t  = ((t * x2) >> 28) / 64'd110;
        s  = s - t;
        t  = ((t * x2) >> 28) / 64'd156;
        s  = s + t;
        t  = ((t * x2) >> 28) / 64'd210;
        s  = s - t;
        return s;
    endfunction

    // Angle whose sine is nearest to k / ASIN_TABLE_DEPTH, the lower one on a tie.
    function automatic int unsigned asin_entry(input int unsigned k);
        longint unsigned s;
        longint unsigned up;
        longint unsigned dn;
        longint unsigned eu;
        longint unsigned ed;
        int unsigned     lo;
        int unsigned     hi;
        int unsigned     mid;
        s  = (64'(k) << 28) / ASIN_TABLE_DEPTH;
        lo = 0;
        hi = ANGLE_MAX;
        while (lo < hi) begin
            mid = (lo + hi) >> 1;
            if (sine_q28(mid) >= s) begin
                hi = mid;
            end else begin
                lo = mid + 1;
            end
        end
        if (lo > 0) begin
            up = sine_q28(lo);
            dn = sine_q28(lo - 1);
            eu = (up >= s) ? up - s : s - up;
            ed = (dn >= s) ? dn - s : s - dn;
            if (ed <= eu) begin
                lo = lo - 1;
            end
        end
        return lo;
    endfunction

    // Arcsine magnitude for a height offset magnitude from the arm base.
    function automatic logic [ANGLE_W-1:0] asin_of_mag(input int unsigned mag);
        longint unsigned u;
        longint unsigned idx;
        u   = (64'(mag) * 64'(ARM_INV_RADIUS) + 64'd2048) >> 12;
        idx = (u * 64'(ASIN_TABLE_DEPTH) + 64'd2048) >> 12;
        if (idx > 64'(ASIN_TABLE_DEPTH)) begin
            idx = 64'(ASIN_TABLE_DEPTH);
        end
        return ANGLE_W'(asin_entry(32'(idx)));
    endfunction

    localparam logic [ANGLE_W-1:0] REACH_BASE = asin_of_mag(ARM_TOP_OFFSET);

    // Round a Q.24 product to Q.12 away from zero on half, saturate to the velocity limit.
    function automatic logic signed [12:0] vel_round(input logic signed [30:0] p);
        logic [30:0] mag;
        logic [31:0] sum;
        logic [19:0] q;
        logic [12:0] res;
        mag = p[30] ? 31'(-p) : 31'(p);
        sum = {1'b0, mag} + 32'd2048;
        q   = sum[31:12];
        if (q > 20'd2048) begin
            q = 20'd2048;
        end
        res = 13'(q);
        return p[30] ? 13'(-res) : res;
    endfunction

endpackage

### src/pick_sequence_controller.sv
// Pick sequence controller: tick-driven grasp sequencer with an APB register file.
// Depends on psc_pkg for codes, constants, the command struct and the arcsine table.
//
// Channel    Direction  Content
// s_axis     in         tuser: kind; tdata: pos_x, pos_y, pos_z
// m_axis     out        tdata: one command set per tick request
// apb        in/out     eight configuration registers at byte address 4*i
//
// One request is accepted per cycle while s_axis_tready is high; after the input register a
// tick result passes the sequencer, then multiply and angle ROM read, then rounding into the
// result register, which drives m_axis.
// Start and detection requests update state and produce no result.
// Reset is synchronous; it loads the register defaults and puts the sequencer in ready.
// A stalled output backs up the four stages; s_axis_tready falls only when all are full.
module pick_sequence_controller
    import psc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // pos_x[15:0], pos_y[31:16], pos_z[47:32]
    input  logic [1:0]  s_axis_tuser,   // kind[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // move_valid[0], vel_forward[13:1], vel_lateral[26:14], arm_valid[27],
    // shoulder_angle[41:28], elbow_angle[55:42], wrist_angle[69:56], grip_valid[70],
    // grip_width[82:71], done_report[83], phase_now[86:84], zero[87]
    output logic [87:0] m_axis_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam logic signed [16:0] Z_LO = 17'(ARM_MIN_Z);
    localparam logic signed [16:0] Z_HI = 17'(ARM_MAX_Z);

    // Configuration registers.
    logic        [14:0] r_standoff;
    logic signed [15:0] r_lateral;
    logic        [13:0] r_gain_fwd;
    logic        [13:0] r_gain_lat;
    logic signed [12:0] r_height;
    logic        [11:0] r_grip_closed;
    logic        [11:0] r_fwd_tol;
    logic        [11:0] r_lat_tol;

    // Sequencer state.
    logic        [2:0]  r_phase;
    logic        [7:0]  r_tick_count;
    logic signed [15:0] r_target_x;
    logic signed [15:0] r_target_y;
    logic signed [15:0] r_target_z;
    logic        [2:0]  n_phase;
    logic        [7:0]  n_tick_count;
    logic signed [15:0] n_target_x;
    logic signed [15:0] n_target_y;
    logic signed [15:0] n_target_z;

    // Stage 0: input register.
    logic               r_s0_v;
    logic        [1:0]  r_s0_kind;
    logic signed [15:0] r_s0_x;
    logic signed [15:0] r_s0_y;
    logic signed [15:0] r_s0_z;

    // Stage 1: resolved commands and operands.
    logic               r_s1_v;
    t_cmd               r_s1_cmd;
    logic signed [16:0] r_s1_ex;
    logic signed [16:0] r_s1_ey;
    logic [ROM_AW-1:0]  r_s1_mag;
    logic               r_s1_dneg;

    // Stage 2: products and table angle.
    logic                r_s2_v;
    t_cmd                r_s2_cmd;
    logic signed [30:0]  r_s2_px;
    logic signed [30:0]  r_s2_py;
    logic [ANGLE_W-1:0]  r_s2_tab;
    logic                r_s2_dneg;

    // Result register.
    logic               r_out_v;
    logic               r_out_mv;
    logic signed [12:0] r_out_vf;
    logic signed [12:0] r_out_vl;
    logic               r_out_av;
    logic signed [13:0] r_out_sa;
    logic signed [13:0] r_out_ea;
    logic signed [13:0] r_out_wa;
    logic               r_out_gv;
    logic        [11:0] r_out_gw;
    logic               r_out_dr;
    logic        [2:0]  r_out_ph;

    // Handshake chain.
    logic w_rdy_out;
    logic w_rdy2;
    logic w_rdy1;
    logic w_adv0;

    // Stage 0 logic.
    logic signed [16:0] w_ex;
    logic signed [16:0] w_ey;
    logic        [16:0] w_ex_abs;
    logic        [16:0] w_ey_abs;
    logic               w_aim_done;
    logic signed [16:0] w_z;
    logic        [10:0] w_zc;
    logic               w_dneg;
    logic [ROM_AW-1:0]  w_mag;
    logic               w_produce;
    t_cmd               w_cmd;

    // Stage 1 and output logic.
    logic signed [31:0] w_px;
    logic signed [31:0] w_py;
    logic signed [14:0] w_sh;
    logic signed [12:0] w_vf;
    logic signed [12:0] w_vl;
    logic signed [13:0] w_sa;
    logic signed [13:0] w_ea;
    logic signed [13:0] w_wa;

    logic [ANGLE_W-1:0] w_asin_rom [ROM_DEPTH];

    // Constant arcsine ROM, indexed by offset magnitude.
    for (genvar g = 0; g < ROM_DEPTH; g++) begin : g_rom
        assign w_asin_rom[g] = asin_of_mag(g);
    end

    assign w_rdy_out     = !r_out_v || m_axis_tready;
    assign w_rdy2        = !r_s2_v || w_rdy_out;
    assign w_rdy1        = !r_s1_v || w_rdy2;
    assign w_adv0        = r_s0_v && w_rdy1;
    assign s_axis_tready = !r_s0_v || w_rdy1;
    assign m_axis_tvalid = r_out_v;
    assign pready        = 1'b1;

    // Aim errors and tolerance check.
    assign w_ex       = 17'(r_target_x) - $signed({2'b00, r_standoff});
    assign w_ey       = 17'(r_target_y) - 17'(r_lateral);
    assign w_ex_abs   = w_ex[16] ? 17'(-w_ex) : 17'(w_ex);
    assign w_ey_abs   = w_ey[16] ? 17'(-w_ey) : 17'(w_ey);
    assign w_aim_done = (w_ex_abs < {5'd0, r_fwd_tol}) && (w_ey_abs < {5'd0, r_lat_tol});

    // Reach height, clamped, split into sign and magnitude about the arm base.
    assign w_z    = 17'(r_target_z) + 17'(r_height);
    assign w_zc   = (w_z < Z_LO) ? 11'(ARM_MIN_Z) :
                    (w_z > Z_HI) ? 11'(ARM_MAX_Z) : w_z[10:0];
    assign w_dneg = w_zc < 11'(ARM_BASE_Z);
    assign w_mag  = w_dneg ? ROM_AW'(11'(ARM_BASE_Z) - w_zc) : ROM_AW'(w_zc - 11'(ARM_BASE_Z));

    // Sequencer: a phase entered during a tick also runs in that tick.
    always_comb begin
        n_phase      = r_phase;
        n_tick_count = r_tick_count;
        n_target_x   = r_target_x;
        n_target_y   = r_target_y;
        n_target_z   = r_target_z;
        w_produce    = 1'b0;
        w_cmd        = '0;
        if (r_s0_kind == KIND_START || (r_s0_kind == KIND_DETECT && r_phase == PH_AIM)) begin
            n_target_x = r_s0_x;
            n_target_y = r_s0_y;
            n_target_z = r_s0_z;
            if (r_s0_kind == KIND_START) begin
                n_phase = PH_AIM;
            end
        end else if (r_s0_kind == KIND_TICK) begin
            w_produce = 1'b1;
            if (n_phase == PH_AIM) begin
                w_cmd.mv   = 1'b1;
                w_cmd.vsel = VS_AIM;
                if (w_aim_done) begin
                    w_cmd.vsel   = VS_ZERO;
                    n_tick_count = '0;
                    n_phase      = PH_REACH;
                end
            end
            if (n_phase == PH_REACH) begin
                if (n_tick_count == '0) begin
                    w_cmd.asel = AS_REACH;
                    w_cmd.gv   = 1'b1;
                    w_cmd.gw   = GRIP_OPEN;
                end
                n_tick_count = n_tick_count + 8'd1;
                if (n_tick_count > REACH_TICKS) begin
                    n_tick_count = '0;
                    n_phase      = PH_FORWARD;
                end
            end
            if (n_phase == PH_FORWARD) begin
                w_cmd.mv     = 1'b1;
                w_cmd.vsel   = VS_FWD;
                n_tick_count = n_tick_count + 8'd1;
                if (n_tick_count > FORWARD_TICKS) begin
                    n_tick_count = '0;
                    n_phase      = PH_GRIP;
                end
            end
            if (n_phase == PH_GRIP) begin
                w_cmd.mv     = 1'b1;
                w_cmd.vsel   = VS_ZERO;
                w_cmd.gv     = 1'b1;
                w_cmd.gw     = r_grip_closed;
                n_tick_count = n_tick_count + 8'd1;
                if (n_tick_count > GRIP_TICKS) begin
                    n_tick_count = '0;
                    n_phase      = PH_TUCK;
                end
            end
            if (n_phase == PH_TUCK) begin
                w_cmd.mv     = 1'b1;
                w_cmd.vsel   = VS_ZERO;
                w_cmd.asel   = AS_TUCK;
                n_tick_count = n_tick_count + 8'd1;
                if (n_tick_count > TUCK_TICKS) begin
                    n_tick_count = '0;
                    n_phase      = PH_BACK;
                end
            end
            if (n_phase == PH_BACK) begin
                w_cmd.mv     = 1'b1;
                w_cmd.vsel   = VS_BACK;
                n_tick_count = n_tick_count + 8'd1;
                if (n_tick_count > BACK_TICKS) begin
                    n_tick_count = '0;
                    n_phase      = PH_DONE;
                end
            end
            if (n_phase == PH_DONE) begin
                if (n_tick_count < DONE_TICKS) begin
                    w_cmd.mv   = 1'b1;
                    w_cmd.vsel = VS_ZERO;
                    w_cmd.dr   = 1'b1;
                end
                if (n_tick_count < COUNT_MAX) begin
                    n_tick_count = n_tick_count + 8'd1;
                end
            end
            w_cmd.ph = n_phase;
        end
    end

    // Proportional terms.
    assign w_px = r_s1_ex * $signed({1'b0, r_gain_fwd});
    assign w_py = r_s1_ey * $signed({1'b0, r_gain_lat});

    // Final command values.
    assign w_sh = r_s2_dneg ? $signed({2'b00, REACH_BASE}) + $signed({2'b00, r_s2_tab})
                            : $signed({2'b00, REACH_BASE}) - $signed({2'b00, r_s2_tab});

    always_comb begin
        unique case (r_s2_cmd.vsel)
            VS_AIM:  w_vf = vel_round(r_s2_px);
            VS_FWD:  w_vf = VEL_CREEP;
            VS_BACK: w_vf = -VEL_CREEP;
            default: w_vf = '0;
        endcase
        w_vl = (r_s2_cmd.vsel == VS_AIM) ? vel_round(r_s2_py) : 13'sd0;
        unique case (r_s2_cmd.asel)
            AS_REACH: begin
                w_sa = w_sh[13:0];
                w_ea = '0;
                w_wa = 14'(-w_sh);
            end
            AS_TUCK: begin
                w_sa = -TUCK_ANGLE;
                w_ea = TUCK_ANGLE;
                w_wa = '0;
            end
            default: begin
                w_sa = '0;
                w_ea = '0;
                w_wa = '0;
            end
        endcase
    end

    // Control registers, state and configuration.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_v        <= 1'b0;
            r_s1_v        <= 1'b0;
            r_s2_v        <= 1'b0;
            r_out_v       <= 1'b0;
            r_phase       <= PH_READY;
            r_tick_count  <= '0;
            r_target_x    <= '0;
            r_target_y    <= '0;
            r_target_z    <= '0;
            r_standoff    <= STANDOFF_RST;
            r_lateral     <= LATERAL_RST;
            r_gain_fwd    <= GAIN_RST;
            r_gain_lat    <= GAIN_RST;
            r_height      <= HEIGHT_RST;
            r_grip_closed <= GRIP_CLOSED_RST;
            r_fwd_tol     <= FWD_TOL_RST;
            r_lat_tol     <= LAT_TOL_RST;
        end else begin
            if (s_axis_tready) begin
                r_s0_v <= s_axis_tvalid;
            end
            if (w_rdy1) begin
                r_s1_v <= w_adv0 && w_produce;
            end
            if (w_rdy2) begin
                r_s2_v <= r_s1_v;
            end
            if (w_rdy_out) begin
                r_out_v <= r_s2_v;
            end
            if (w_adv0) begin
                r_phase      <= n_phase;
                r_tick_count <= n_tick_count;
                r_target_x   <= n_target_x;
                r_target_y   <= n_target_y;
                r_target_z   <= n_target_z;
            end
            if (psel && penable && pwrite) begin
                unique case (paddr[4:2])
                    REG_STANDOFF:    r_standoff    <= pwdata[14:0];
                    REG_LATERAL:     r_lateral     <= pwdata[15:0];
                    REG_GAIN_FWD:    r_gain_fwd    <= pwdata[13:0];
                    REG_GAIN_LAT:    r_gain_lat    <= pwdata[13:0];
                    REG_HEIGHT:      r_height      <= pwdata[12:0];
                    REG_GRIP_CLOSED: r_grip_closed <= pwdata[11:0];
                    REG_FWD_TOL:     r_fwd_tol     <= pwdata[11:0];
                    REG_LAT_TOL:     r_lat_tol     <= pwdata[11:0];
                endcase
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_s0_kind <= s_axis_tuser;
            r_s0_x    <= s_axis_tdata[15:0];
            r_s0_y    <= s_axis_tdata[31:16];
            r_s0_z    <= s_axis_tdata[47:32];
        end
        if (w_adv0) begin
            r_s1_cmd  <= w_cmd;
            r_s1_ex   <= w_ex;
            r_s1_ey   <= w_ey;
            r_s1_mag  <= w_mag;
            r_s1_dneg <= w_dneg;
        end
        if (w_rdy2 && r_s1_v) begin
            r_s2_cmd  <= r_s1_cmd;
            r_s2_px   <= w_px[30:0];
            r_s2_py   <= w_py[30:0];
            r_s2_tab  <= w_asin_rom[r_s1_mag];
            r_s2_dneg <= r_s1_dneg;
        end
        if (w_rdy_out && r_s2_v) begin
            r_out_mv <= r_s2_cmd.mv;
            r_out_vf <= w_vf;
            r_out_vl <= w_vl;
            r_out_av <= r_s2_cmd.asel != AS_NONE;
            r_out_sa <= w_sa;
            r_out_ea <= w_ea;
            r_out_wa <= w_wa;
            r_out_gv <= r_s2_cmd.gv;
            r_out_gw <= r_s2_cmd.gw;
            r_out_dr <= r_s2_cmd.dr;
            r_out_ph <= r_s2_cmd.ph;
        end
    end

    assign m_axis_tdata = {1'b0, r_out_ph, r_out_dr, r_out_gw, r_out_gv, r_out_wa, r_out_ea,
                           r_out_sa, r_out_av, r_out_vl, r_out_vf, r_out_mv};

    always_comb begin
        unique case (paddr[4:2])
            REG_STANDOFF:    prdata = {17'd0, r_standoff};
            REG_LATERAL:     prdata = {{16{r_lateral[15]}}, r_lateral};
            REG_GAIN_FWD:    prdata = {18'd0, r_gain_fwd};
            REG_GAIN_LAT:    prdata = {18'd0, r_gain_lat};
            REG_HEIGHT:      prdata = {{19{r_height[12]}}, r_height};
            REG_GRIP_CLOSED: prdata = {20'd0, r_grip_closed};
            REG_FWD_TOL:     prdata = {20'd0, r_fwd_tol};
            REG_LAT_TOL:     prdata = {20'd0, r_lat_tol};
        endcase
    end

    // A tick that leaves the input register always lands in stage 1.
    a_tick_to_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv0 && r_s0_kind == KIND_TICK) |=> r_s1_v)
        else $error("tick request lost between input register and stage 1");

    // The reach counter never runs past its length.
    a_reach_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_REACH) |-> (r_tick_count <= REACH_TICKS))
        else $error("reach tick count out of range");

    // Done is only reported in the done phase, together with a stop command.
    a_done_stop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && r_out_dr) |-> (r_out_ph == PH_DONE && r_out_mv && r_out_vf == 13'sd0))
        else $error("done report without stop in done phase");

    // Base velocities stay within the saturation limit.
    a_vel_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_v |-> (r_out_vf <= VEL_LIMIT && r_out_vf >= -VEL_LIMIT &&
                     r_out_vl <= VEL_LIMIT && r_out_vl >= -VEL_LIMIT))
        else $error("velocity command beyond limit");

endmodule
